[design/pic_pkg.sv]
// Shared types, command and error codes, and a helper of the priority interrupt controller.
package pic_pkg;

   // Every held register is this wide, whatever the line count.
   localparam int REG_WIDTH  = 16;
   localparam int LINE_COUNT = 16;

   // Lines at or above LINE_COUNT are never held.
   localparam logic [REG_WIDTH-1:0] LINE_MASK =
      (LINE_COUNT >= REG_WIDTH) ? {REG_WIDTH{1'b1}} :
      REG_WIDTH'((64'd1 << LINE_COUNT) - 64'd1);

   localparam logic [REG_WIDTH-1:0] NMI_RESET = REG_WIDTH'(1);

   // Command codes
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_RAISE      = 3'd1;
   localparam logic [2:0] CMD_EOI        = 3'd2;
   localparam logic [2:0] CMD_WR_ENABLE  = 3'd3;
   localparam logic [2:0] CMD_WR_PENDING = 3'd4;
   localparam logic [2:0] CMD_READ       = 3'd5;

   // Error codes
   localparam logic [2:0] ERR_OK           = 3'd0;
   localparam logic [2:0] ERR_EOI_NONE     = 3'd1;
   localparam logic [2:0] ERR_ACK_NONE     = 3'd2;
   localparam logic [2:0] ERR_BAD_CMD      = 3'd3;
   localparam logic [2:0] ERR_RAISE_IN_SVC = 3'd4;

   typedef struct packed {
      logic [2:0]           command;
      logic [3:0]           line_number;
      logic [REG_WIDTH-1:0] write_value;
      logic                 ack_level;
   } req_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] in_service_bits;
      logic                 request_line;
      logic [2:0]           error_code;
   } rsp_type;

   // Isolate the lowest set bit (highest priority line).
   function automatic logic [REG_WIDTH-1:0] lowest_set(input logic [REG_WIDTH-1:0] v);
      return v & (~v + REG_WIDTH'(1));
   endfunction

endpackage

[design/priority_interrupt_controller_top.sv]
// Top level of the priority interrupt controller: beat registers, handshake and CSR.
// Fixed-priority interrupt controller for 16 lines (line 0 highest). Each request
// beat is a tick carrying the acknowledge level, a line raise, end-of-interrupt,
// a mask write, a pending write or a read; each one yields exactly one response
// beat with the in-service bits, the request line and an error code, in order.
// Timing: a request beat lands in an input register; when it fires, the state
// update and result are worked out in one pass and written to the response register.
// One beat per cycle is taken sustained while no response is held by rsp_stall;
// the input register keeps taking a beat while a
// finished response is held by rsp_stall, and req_stall rises only when both
// registers are full. The NMI line mask (reset 1) is written through csr_wr_en
// and csr_wr_data and should be changed only when no beat is in flight.
module priority_interrupt_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pic_pkg::req_type              req_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pic_pkg::rsp_type              rsp_data,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [pic_pkg::REG_WIDTH-1:0] csr_wr_data
);

   logic                          req_valid_ff, req_valid_in;
   pic_pkg::req_type              req_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   pic_pkg::rsp_type              rsp_data_ff;
   logic [pic_pkg::REG_WIDTH-1:0] nmi_ff;
   pic_pkg::rsp_type              result;
   logic                          accept;
   logic                          fire;

   // fire: the held beat is processed and moves into the response register
   assign fire      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign req_valid_in = accept || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nmi_ff       <= pic_pkg::NMI_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            nmi_ff <= csr_wr_data;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   pic_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (req_data_ff),
      .nmi_lines (nmi_ff),
      .result    (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/pic_core.sv]
// Controller state registers and the single-pass next-state and result logic.
module pic_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  pic_pkg::req_type            item,
   input  logic [pic_pkg::REG_WIDTH-1:0] nmi_lines,
   output pic_pkg::rsp_type            result
);

   logic [pic_pkg::REG_WIDTH-1:0] pending_ff, pending_in;
   logic [pic_pkg::REG_WIDTH-1:0] enable_ff, enable_in;
   logic [pic_pkg::REG_WIDTH-1:0] service_ff, service_in;
   logic                          ack_prev_ff, ack_prev_in;

   logic [pic_pkg::REG_WIDTH-1:0] nmi_eff;
   logic [pic_pkg::REG_WIDTH-1:0] pick;
   logic [pic_pkg::REG_WIDTH-1:0] line_bit;
   logic                          line_ok;
   logic [2:0]                    err;
   logic                          any_req;
   logic                          nmi_req;

   assign nmi_eff  = nmi_lines & pic_pkg::LINE_MASK;
   assign pick     = pic_pkg::lowest_set(pending_ff & (enable_ff | nmi_eff) & pic_pkg::LINE_MASK);
   assign line_bit = pic_pkg::REG_WIDTH'(1) << item.line_number;
   assign line_ok  = 32'(item.line_number) < pic_pkg::LINE_COUNT;

   always_comb begin
      pending_in  = pending_ff;
      enable_in   = enable_ff;
      service_in  = service_ff;
      ack_prev_in = ack_prev_ff;
      err         = pic_pkg::ERR_OK;
      unique case (item.command)
         pic_pkg::CMD_TICK: begin
            ack_prev_in = item.ack_level;
            // rising acknowledge edge moves the winner to in-service
            if (item.ack_level && !ack_prev_ff) begin
               if (pick == '0) begin
                  err = pic_pkg::ERR_ACK_NONE;
               end else begin
                  service_in = service_ff | pick;
                  pending_in = pending_ff & ~pick;
               end
            end
         end
         pic_pkg::CMD_RAISE: begin
            if (line_ok) begin
               if ((service_ff & line_bit) != '0) begin
                  err = pic_pkg::ERR_RAISE_IN_SVC;
               end else begin
                  pending_in = pending_ff | line_bit;
               end
            end
         end
         pic_pkg::CMD_EOI: begin
            if (service_ff == '0) begin
               err = pic_pkg::ERR_EOI_NONE;
            end else begin
               service_in = service_ff & ~pic_pkg::lowest_set(service_ff);
            end
         end
         pic_pkg::CMD_WR_ENABLE:  enable_in  = item.write_value & pic_pkg::LINE_MASK;
         pic_pkg::CMD_WR_PENDING: pending_in = item.write_value & pic_pkg::LINE_MASK;
         pic_pkg::CMD_READ: ;
         default: err = pic_pkg::ERR_BAD_CMD;
      endcase
   end

   // request output as seen after this beat
   assign any_req = (service_in == '0) &&
                    ((pending_in & (enable_in | nmi_eff) & pic_pkg::LINE_MASK) != '0);
   assign nmi_req = ((service_in & nmi_eff) == '0) && ((pending_in & nmi_eff) != '0);

   assign result.in_service_bits = service_in;
   assign result.request_line    = any_req | nmi_req;
   assign result.error_code      = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         enable_ff   <= '0;
         service_ff  <= '0;
         ack_prev_ff <= 1'b0;
      end else if (fire) begin
         pending_ff  <= pending_in;
         enable_ff   <= enable_in;
         service_ff  <= service_in;
         ack_prev_ff <= ack_prev_in;
      end
   end

endmodule

[design/pic_checker.sv]
// Port-level assertions for the priority interrupt controller and their bind.
module pic_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pic_pkg::rsp_type rsp_data
);

   // a held response keeps its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // input backpressure only when a response is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a blocked response");

   // an accepted beat reaches the response register when the output is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("accepted beat produced no response");

   // end-of-interrupt error only when nothing is in service
   a_eoi_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code == pic_pkg::ERR_EOI_NONE)
      |-> rsp_data.in_service_bits == '0)
      else $error("EOI error with lines in service");

endmodule

bind priority_interrupt_controller_top pic_checker u_pic_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
